// ----- rtl/sse_pkg.sv -----
// Shared types and constants for the sorting stack engine.
package sse_pkg;

    // Width of the value fields on the stream ports.
    localparam int unsigned PORT_VALUE_W = 32;
    localparam int unsigned FUNC_W       = 2;

    // Command codes carried in s_tuser.
    localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SORT = 2'd2;

    typedef enum logic {
        SSE_IDLE,
        SSE_SORT
    } sse_state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP,
        CELL_SORT
    } cell_op_t;

    // Per-cell control: the shared operation plus this cell's role in the
    // current compare-exchange phase.
    typedef struct packed {
        cell_op_t op;
        logic     pair_down;  // upper member of an active pair with the cell below
        logic     pair_up;    // lower member of an active pair with the cell above
    } sse_cell_ctl_t;

endpackage

// ----- rtl/sse_cell.sv -----
// One stack cell: holds a single entry and trades it with its neighbors.
module sse_cell
    import sse_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  sse_cell_ctl_t          ctl,
    input  logic [VALUE_WIDTH-1:0] above_val,
    input  logic [VALUE_WIDTH-1:0] below_val,
    output logic [VALUE_WIDTH-1:0] val
);

    logic [VALUE_WIDTH-1:0] val_reg;
    logic [VALUE_WIDTH-1:0] val_next;
    logic                   below_gt;
    logic                   self_gt_above;

    assign below_gt      = $signed(below_val) > $signed(val_reg);
    assign self_gt_above = $signed(val_reg) > $signed(above_val);

    always_comb begin
        val_next = val_reg;
        case (ctl.op)
            CELL_PUSH: val_next = above_val;
            CELL_POP:  val_next = below_val;
            CELL_SORT: begin
                // keep the larger value toward the top
                if (ctl.pair_down) begin
                    val_next = below_gt ? below_val : val_reg;
                end else if (ctl.pair_up) begin
                    val_next = self_gt_above ? above_val : val_reg;
                end
            end
            default: val_next = val_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

// ----- rtl/sorting_stack_engine.sv -----
// Top level of the sorting stack engine: cell chain, command control, result beat.
//
// A bounded stack of signed words built as a chain of STACK_DEPTH cells, cell 0
// holding the top entry. Each input beat carries one command in s_tuser (push,
// pop, sort) and the value to push in s_tdata; each command returns exactly one
// result beat. Push and pop shift the whole chain by one place at once, so
// they may follow each other back to back as long as results are taken. Sort
// runs an odd-even transposition over the occupied cells, one compare-exchange
// phase per cycle, leaving the smallest value at the bottom and the largest on
// top; it runs one phase per entry on the stack before loading its result, and
// no new beat is accepted meanwhile. A push onto a full stack or a pop from an
// empty one is dropped and flagged in the error field; a pop from an empty
// stack reports zero. Unused command codes change nothing and report the
// current stack. The result register decouples the two sides: a new command
// is taken in the same cycle a waiting result is taken.
module sorting_stack_engine
    import sse_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 256,
    parameter int unsigned VALUE_WIDTH = 32,
    localparam int unsigned DEPTH_W    = $clog2(STACK_DEPTH + 1),
    localparam int unsigned OUT_BITS   = 2 * PORT_VALUE_W + DEPTH_W + 2,
    localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // command channel
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [PORT_VALUE_W-1:0] s_tdata,   // push_value
    input  logic [FUNC_W-1:0]       s_tuser,   // func
    // result channel
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // popped_value, depth, empty_res, top_value, error (zero padded)
    output logic [OUT_TDATA_W-1:0]  m_tdata
);

    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    sse_state_t         state_reg, state_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [DEPTH_W-1:0] cnt_reg, cnt_next;      // sort phases left
    logic               phase_reg, phase_next;  // 0: even pairs, 1: odd pairs
    cell_op_t           cell_op;

    // Result register
    logic                    m_tvalid_reg;
    logic                    out_load;
    logic [PORT_VALUE_W-1:0] popped_reg, popped_next;
    logic [DEPTH_W-1:0]      res_depth_reg;
    logic [PORT_VALUE_W-1:0] top_reg, top_next;
    logic                    error_reg, error_next;

    logic                   accept;
    logic [VALUE_WIDTH-1:0] push_ext;

    // ---------------------------------------------------------------
    // Cell chain
    // ---------------------------------------------------------------
    logic [VALUE_WIDTH-1:0] cell_val [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] cell_valid;
    sse_cell_ctl_t          cell_ctl [STACK_DEPTH];

    assign push_ext = VALUE_WIDTH'($signed(s_tdata));

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        localparam logic PARITY = 1'(i % 2);
        logic [VALUE_WIDTH-1:0] above;
        logic [VALUE_WIDTH-1:0] below;

        assign cell_valid[i] = DEPTH_W'(i) < depth_reg;

        if (i == 0) begin : g_top
            assign above          = push_ext;
            assign cell_ctl[i].pair_up = 1'b0;
        end else begin : g_mid
            assign above          = cell_val[i-1];
            assign cell_ctl[i].pair_up = (PARITY != phase_reg) && cell_valid[i];
        end

        if (i == STACK_DEPTH - 1) begin : g_bot
            assign below            = '0;
            assign cell_ctl[i].pair_down = 1'b0;
        end else begin : g_upper
            assign below            = cell_val[i+1];
            assign cell_ctl[i].pair_down = (PARITY == phase_reg) && cell_valid[i+1];
        end

        assign cell_ctl[i].op = cell_op;

        sse_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (cell_ctl[i]),
            .above_val (above),
            .below_val (below),
            .val       (cell_val[i])
        );
    end

    // ---------------------------------------------------------------
    // Command control
    // ---------------------------------------------------------------
    // Take a command only when idle and the result slot is free or draining.
    assign s_tready = (state_reg == SSE_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next  = state_reg;
        depth_next  = depth_reg;
        cnt_next    = cnt_reg;
        phase_next  = phase_reg;
        cell_op     = CELL_HOLD;
        out_load    = 1'b0;
        popped_next = '0;
        error_next  = 1'b0;
        top_next    = (depth_reg != '0) ? PORT_VALUE_W'($signed(cell_val[0])) : '0;

        case (state_reg)
            SSE_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        FUNC_PUSH: begin
                            out_load = 1'b1;
                            if (depth_reg == DEPTH_FULL) begin
                                error_next = 1'b1;
                            end else begin
                                cell_op    = CELL_PUSH;
                                depth_next = depth_reg + DEPTH_W'(1);
                                top_next   = PORT_VALUE_W'($signed(push_ext));
                            end
                        end
                        FUNC_POP: begin
                            out_load = 1'b1;
                            if (depth_reg == '0) begin
                                error_next = 1'b1;
                            end else begin
                                cell_op     = CELL_POP;
                                depth_next  = depth_reg - DEPTH_W'(1);
                                popped_next = PORT_VALUE_W'($signed(cell_val[0]));
                                top_next    = cell_valid[1] ?
                                              PORT_VALUE_W'($signed(cell_val[1])) : '0;
                            end
                        end
                        FUNC_SORT: begin
                            // depth phases of odd-even transposition settle the chain
                            state_next = SSE_SORT;
                            cnt_next   = depth_reg;
                            phase_next = 1'b0;
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            SSE_SORT: begin
                if (cnt_reg != '0) begin
                    cell_op    = CELL_SORT;
                    cnt_next   = cnt_reg - DEPTH_W'(1);
                    phase_next = ~phase_reg;
                end else begin
                    out_load   = 1'b1;
                    state_next = SSE_IDLE;
                end
            end
            default: begin
                state_next = SSE_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SSE_IDLE;
            depth_reg <= '0;
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            popped_reg    <= popped_next;
            res_depth_reg <= depth_next;
            top_reg       <= top_next;
            error_reg     <= error_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'({error_reg, top_reg, (res_depth_reg == '0),
                                    res_depth_reg, popped_reg});

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_FULL)
        else $error("stack depth beyond capacity");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SSE_SORT) |-> !s_tready)
        else $error("command accepted during sort");

    a_push_lands_on_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser == FUNC_PUSH) && (depth_reg != DEPTH_FULL))
        |=> (cell_val[0] == $past(push_ext)))
        else $error("pushed value not on top");

    a_sort_keeps_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SSE_SORT) |=> (depth_reg == $past(depth_reg)))
        else $error("depth changed during sort");

    a_error_pops_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && error_next) |=> (popped_reg == '0))
        else $error("failed command reported a popped value");

endmodule
